>>> rtl/klti_pkg.sv
// ----------------------------------------------------------------------------
// klti_pkg
// Shared types and constants for the ordered key list with tail insert and
// first-match remove.
// ----------------------------------------------------------------------------
package klti_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 5;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

endpackage

>>> rtl/klti_store.sv
// ----------------------------------------------------------------------------
// klti_store
// Key memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module klti_store
  import klti_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic signed [KEY_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic signed [KEY_W-1:0] rd_data
);

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/klti_ctrl.sv
// ----------------------------------------------------------------------------
// klti_ctrl
// Request sequencer: takes one request, walks the key memory through the
// shared key comparator and closes the gap after a removal.
// ----------------------------------------------------------------------------
module klti_ctrl
  import klti_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  in_item_t                req,
  output logic                    res_valid,
  input  logic                    res_ready,
  output out_item_t               res,
  output logic                    wr_en,
  output logic [IDX_W-1:0]        wr_addr,
  output logic signed [KEY_W-1:0] wr_data,
  output logic                    rd_en,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic signed [KEY_W-1:0] rd_data
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  logic signed [KEY_W-1:0] key_r;
  status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;

  logic [CNT_W-1:0]        idx_inc;
  logic                    key_hit;
  logic                    at_last;

  // shared compare unit: stored key against the request key
  assign key_hit = (rd_data == key_r);
  assign idx_inc = CNT_W'(rd_idx_r) + 1'b1;
  assign at_last = (idx_inc >= count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op_r  <= req.operation;
      key_r <= req.key;
    end
    status_r <= status_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_idx_nxt = '0;
        if (op_r == OP_APPEND) begin
          state_nxt = S_DONE;
          if (count_r >= FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_OK;
            count_nxt  = CNT_W'(count_r + 1'b1);
          end
        end else if (count_r == '0) begin
          state_nxt  = S_DONE;
          status_nxt = ST_EMPTY;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        rd_idx_nxt = idx_inc[IDX_W-1:0];
        if (key_hit) begin
          status_nxt = ST_OK;
          if (at_last) begin
            state_nxt = S_DONE;
            count_nxt = CNT_W'(count_r - 1'b1);
          end else begin
            // read of the following entry is already in flight
            state_nxt = S_SHIFT;
          end
        end else if (at_last) begin
          state_nxt  = S_DONE;
          status_nxt = ST_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        rd_idx_nxt = idx_inc[IDX_W-1:0];
        if (at_last) begin
          state_nxt = S_DONE;
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = count_r[IDX_W-1:0];
    wr_data   = key_r;
    rd_en     = 1'b0;
    rd_addr   = idx_inc[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_EXEC: begin
        rd_addr = '0;
        if (op_r == OP_APPEND) begin
          wr_en = (count_r < FULL_CNT);
        end else begin
          rd_en = 1'b1;
        end
      end
      S_SEARCH: begin
        rd_en = 1'b1;
      end
      S_SHIFT: begin
        // move the entry just read one place toward the head
        rd_en   = 1'b1;
        wr_en   = 1'b1;
        wr_addr = IDX_W'(rd_idx_r - 1'b1);
        wr_data = rd_data;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.count  = COUNT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (rd_idx_r != '0) && (CNT_W'(rd_idx_r) < count_r))
    else $error("shift outside the held entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_FULL) |-> (count_r == FULL_CNT))
    else $error("full reported below depth");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && key_hit && at_last) |=> (count_r == $past(count_r) - 1'b1))
    else $error("count not reduced after removal");

endmodule

>>> rtl/key_list_tail_insert_remove_top.sv
// ----------------------------------------------------------------------------
// key_list_tail_insert_remove_top
// Ordered list of signed keys: append at tail, remove first match with gap
// closing, one status and count result per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_valid/in_ready    in_data   (operation, key)
//  out_     out  out_valid/out_ready  out_data  (status, count)
//
//  append or empty/full answer: exec state, then done; result register loads
//  remove: exec, then the search up to the match and the shift past it, which
//  together read every held entry, one memory read per cycle
//  next request can be taken in the cycle after the result loads
//  reset: synchronous, clears the entry count; key memory is not cleared
//  a result waiting in the output register holds the sequencer in its
//  last state; the next request is taken as soon as it moves on
module key_list_tail_insert_remove_top
  import klti_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        wr_addr, rd_addr;
  logic signed [KEY_W-1:0] wr_data, rd_data;
  logic                    res_valid, res_ready;
  out_item_t               res;

  logic                    out_valid_r;
  out_item_t               out_data_r;

  klti_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  klti_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes a new beat when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
